// File: rtl/fnp_pkg.sv
package fnp_pkg;

    // Field and register widths.
    localparam int FREQ_W   = 33;
    localparam int RETRY_W  = 3;
    localparam int IF_W     = 32;
    localparam int OFS_W    = 28;
    localparam int PFD_W    = 27;
    localparam int VAR_W    = 2;
    localparam int STAT_W   = 2;
    localparam int DIV_W    = 3;
    localparam int WIN_W    = 3;
    localparam int NWORD_W  = 10;
    localparam int FWORD_W  = 18;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;

    // Offset-corrected frequency and VCO frequency widths.
    localparam int F_W  = 34;
    localparam int FV_W = F_W + DIV_W;

    localparam int FRAC_BITS_DEF = 18;
    localparam int N_MAX_DEF     = 1023;

    localparam logic [PFD_W-1:0] PFD_RST = 27'd10000000;
    localparam logic [VAR_W-1:0] VAR_RST = 2'd1;

    // Range band above the IF.
    localparam logic [F_W-1:0] BAND_LO = 34'd500000;
    localparam logic [F_W-1:0] BAND_HI = 34'd1500000000;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IF      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PFD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VARIANT = 3'd3;

    // Retry counts that move the output divider.
    localparam logic [RETRY_W-1:0] RETRY_UP   = 3'd2;
    localparam logic [RETRY_W-1:0] RETRY_DOWN = 3'd1;

    localparam logic [VAR_W-1:0] VAR_LAST = 2'd2;

    typedef struct packed {
        logic [IF_W-1:0]         if_freq;
        logic signed [OFS_W-1:0] tune_offset;
        logic [PFD_W-1:0]        pfd;
        logic [VAR_W-1:0]        variant;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic step;
    } t_div_cmd;

    // Divider ranges per variant, in Hz: low bound exclusive, high bound inclusive.
    // Row r selects divider 6 - r.
    localparam logic [F_W-1:0] DIV_LO [3][6] = '{
        '{34'd373000000,  34'd448000000,  34'd560000000,
          34'd747000000,  34'd1120000000, 34'd2240000000},
        '{34'd640000000,  34'd768000000,  34'd960000000,
          34'd1280000000, 34'd1920000000, 34'd3840000000},
        '{34'd700000000,  34'd1065000000, 34'd1278000000,
          34'd1598000000, 34'd2130000000, 34'd4200000000}
    };
    localparam logic [F_W-1:0] DIV_HI [3][6] = '{
        '{34'd623000000,  34'd748000000,  34'd935000000,
          34'd1247000000, 34'd1870000000, 34'd3740000000},
        '{34'd965000000,  34'd1158000000, 34'd1448000000,
          34'd1930000000, 34'd2895000000, 34'd5790000000},
        '{34'd1065000000, 34'd1278000000, 34'd1598000000,
          34'd2130000000, 34'd3195000000, 34'd6390000000}
    };

    localparam logic [F_W-1:0] WIN_TH [8] = '{
        34'd2970000000, 34'd2000000000, 34'd1390000000, 34'd941000000,
        34'd646000000,  34'd431000000,  34'd294000000,  34'd196000000
    };

    // First matching row wins; the loop runs backward so the earliest match is kept.
    function automatic logic [DIV_W-1:0] pick_divider(input logic [VAR_W-1:0] variant,
                                                      input logic [F_W-1:0] f);
        logic [DIV_W-1:0] d;
        d = 3'd1;
        if (variant <= VAR_LAST) begin
            for (int r = 5; r >= 0; r--) begin
                if (f > DIV_LO[variant][r] && f <= DIV_HI[variant][r]) begin
                    d = DIV_W'(6 - r);
                end
            end
        end
        return d;
    endfunction

    // Below the lowest threshold the window code falls back to 1.
    function automatic logic [WIN_W-1:0] pick_window(input logic [FV_W-1:0] fvco);
        logic [WIN_W-1:0] w;
        w = 3'd1;
        for (int k = 7; k >= 0; k--) begin
            if (fvco >= FV_W'(WIN_TH[k])) begin
                w = WIN_W'(k);
            end
        end
        return w;
    endfunction

endpackage

// File: rtl/fnp_cfg_regs.sv
module fnp_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fnp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fnp_pkg::CFG_W-1:0]     i_cfg_data,
    output fnp_pkg::t_cfg                 o_cfg
);
    import fnp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.if_freq     <= '0;
            r_cfg.tune_offset <= '0;
            r_cfg.pfd         <= PFD_RST;
            r_cfg.variant     <= VAR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IF:      r_cfg.if_freq     <= i_cfg_data[IF_W-1:0];
                CFG_OFFSET:  r_cfg.tune_offset <= signed'(i_cfg_data[OFS_W-1:0]);
                CFG_PFD:     r_cfg.pfd         <= i_cfg_data[PFD_W-1:0];
                CFG_VARIANT: r_cfg.variant     <= i_cfg_data[VAR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/fnp_div_unit.sv
module fnp_div_unit #(
    parameter int PW = 27,
    parameter int LW = 18
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fnp_pkg::t_div_cmd          i_cmd,
    input  logic [$clog2(LW+1)-1:0]    i_steps,
    input  logic [PW-1:0]              i_part,
    input  logic [LW-1:0]              i_low,
    input  logic [PW-1:0]              i_divisor,
    output logic [PW-1:0]              o_part,
    output logic [LW-1:0]              o_low,
    output logic                       o_done
);
    import fnp_pkg::*;

    localparam int CNT_W = $clog2(LW + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [PW-1:0]    r_part;
    logic [LW-1:0]    r_low;
    logic [PW:0]      w_trial;
    logic             w_ge;
    logic [PW:0]      w_diff;

    // Restoring division: bring down the next dividend bit, subtract when it fits.
    assign w_trial = {r_part, r_low[LW-1]};
    assign w_ge    = w_trial >= {1'b0, i_divisor};
    assign w_diff  = w_trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= i_steps;
        end else if (i_cmd.step && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_part <= i_part;
            r_low  <= i_low;
        end else if (i_cmd.step && r_cnt != '0) begin
            r_part <= w_ge ? w_diff[PW-1:0] : w_trial[PW-1:0];
            r_low  <= {r_low[LW-2:0], w_ge};
        end
    end

    assign o_part = r_part;
    assign o_low  = r_low;
    assign o_done = (r_cnt == '0);

endmodule

// File: rtl/frac_n_pll_divider_planner.sv
// Channel   Direction  Handshake                 Payload
// request   in         i_in_valid / o_in_ready   i_freq_hz, i_retries_left
// result    out        o_out_valid / i_out_ready o_status, o_out_div, o_lock_window,
//                                                o_n_word, o_frac_word
// config    in         i_cfg_we (no wait)        i_cfg_idx, i_cfg_data
//
// A request steps through the range check, output divider, VCO frequency, lock window,
// N division on the shared bit-serial divider, N fix-up, fraction scaling, saturation
// check and fraction division; ready returns in the same cycle the result becomes valid.
// A clamped N or saturated fraction skips its division; out-of-range requests skip to done.
// A result still waiting in the output register holds the next one in its last step.
// Reset is synchronous and active low and restores the register defaults.
module frac_n_pll_divider_planner #(
    parameter int FRAC_BITS = fnp_pkg::FRAC_BITS_DEF,
    parameter int N_MAX     = fnp_pkg::N_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fnp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fnp_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [fnp_pkg::FREQ_W-1:0]    i_freq_hz,
    input  logic [fnp_pkg::RETRY_W-1:0]   i_retries_left,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [fnp_pkg::STAT_W-1:0]    o_status,
    output logic [fnp_pkg::DIV_W-1:0]     o_out_div,
    output logic [fnp_pkg::WIN_W-1:0]     o_lock_window,
    output logic [fnp_pkg::NWORD_W-1:0]   o_n_word,
    output logic [fnp_pkg::FWORD_W-1:0]   o_frac_word
);
    import fnp_pkg::*;

    localparam int NW     = $clog2(N_MAX + 1);
    localparam int LW     = (NW > FRAC_BITS) ? NW : FRAC_BITS;
    localparam int CNT_W  = $clog2(LW + 1);
    localparam int NMP_W  = NW + PFD_W;
    localparam int REM_W  = ((FV_W > NMP_W) ? FV_W : NMP_W) + 1;
    localparam int XW     = REM_W + FRAC_BITS;
    localparam int NXW    = (NW > NWORD_W) ? NW : NWORD_W;
    localparam int FXW    = (FRAC_BITS > FWORD_W) ? FRAC_BITS : FWORD_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RANGE = 4'd1;
    localparam logic [3:0] S_ODIV  = 4'd2;
    localparam logic [3:0] S_VCO   = 4'd3;
    localparam logic [3:0] S_WIN   = 4'd4;
    localparam logic [3:0] S_DIV1  = 4'd5;
    localparam logic [3:0] S_NFIX  = 4'd6;
    localparam logic [3:0] S_XMUL  = 4'd7;
    localparam logic [3:0] S_SAT   = 4'd8;
    localparam logic [3:0] S_DIV2  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    t_cfg w_cfg;

    logic [3:0]          r_state;
    logic [FREQ_W-1:0]   r_freq;
    logic [RETRY_W-1:0]  r_retries;
    logic [F_W-1:0]      r_f;
    logic [DIV_W-1:0]    r_odiv;
    logic [FV_W-1:0]     r_fvco;
    logic [NMP_W-1:0]    r_nmp;
    logic [WIN_W-1:0]    r_win;
    logic [REM_W-1:0]    r_rem;
    logic [XW-1:0]       r_x;
    logic [NW-1:0]       r_nm1;
    logic [FRAC_BITS-1:0] r_frac;
    logic [STAT_W-1:0]   r_status;

    logic                r_out_valid;
    logic [STAT_W-1:0]   r_o_status;
    logic [DIV_W-1:0]    r_o_div;
    logic [WIN_W-1:0]    r_o_win;
    logic [NWORD_W-1:0]  r_o_nword;
    logic [FWORD_W-1:0]  r_o_frac;

    logic [PFD_W-1:0]    w_pfd;
    logic [F_W-1:0]      w_band_lo;
    logic [F_W-1:0]      w_band_hi;
    logic                w_out_of_range;
    logic signed [F_W:0] w_adj;
    logic [F_W-1:0]      w_f;
    logic [DIV_W-1:0]    w_odiv;
    logic [REM_W-1:0]    w_fv_ext;
    logic [XW-1:0]       w_x_ext;
    logic [NW-1:0]       w_q;
    logic [NXW-1:0]      w_n_ext;
    logic [FXW-1:0]      w_f_ext;
    logic                w_in_acc;
    logic                w_out_free;

    t_div_cmd            w_div_cmd;
    logic [CNT_W-1:0]    w_div_steps;
    logic [PFD_W-1:0]    w_div_ld_part;
    logic [LW-1:0]       w_div_ld_low;
    logic [PFD_W-1:0]    w_div_part;
    logic [LW-1:0]       w_div_low;
    logic                w_div_done;

    fnp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    fnp_div_unit #(
        .PW (PFD_W),
        .LW (LW)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_div_cmd),
        .i_steps   (w_div_steps),
        .i_part    (w_div_ld_part),
        .i_low     (w_div_ld_low),
        .i_divisor (w_pfd),
        .o_part    (w_div_part),
        .o_low     (w_div_low),
        .o_done    (w_div_done)
    );

    assign w_pfd = (w_cfg.pfd == '0) ? PFD_W'(1) : w_cfg.pfd;

    assign w_band_lo = F_W'(w_cfg.if_freq) + BAND_LO;
    assign w_band_hi = F_W'(w_cfg.if_freq) + BAND_HI;
    assign w_out_of_range = (F_W'(r_freq) < w_band_lo) || (F_W'(r_freq) > w_band_hi);

    assign w_adj = signed'({2'b00, r_freq}) + (F_W+1)'(w_cfg.tune_offset);
    assign w_f   = w_adj[F_W] ? '0 : w_adj[F_W-1:0];

    always_comb begin
        w_odiv = pick_divider(w_cfg.variant, r_f);
        if (r_retries == RETRY_UP) begin
            w_odiv = w_odiv + 1'b1;
        end else if (r_retries == RETRY_DOWN) begin
            w_odiv = w_odiv - 1'b1;
        end
    end

    assign w_fv_ext = REM_W'(r_fvco);
    assign w_x_ext  = r_x;
    assign w_q      = w_div_low[NW-1:0];
    assign w_n_ext  = NXW'(r_nm1);
    assign w_f_ext  = FXW'(r_frac);

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Divider loads: N first with NW quotient bits, then the fraction with FRAC_BITS bits.
    always_comb begin
        w_div_cmd     = '0;
        w_div_steps   = CNT_W'(NW);
        w_div_ld_part = w_fv_ext[NW +: PFD_W];
        w_div_ld_low  = LW'(w_fv_ext[NW-1:0]) << (LW - NW);
        case (r_state)
            S_WIN: begin
                w_div_cmd.load = (r_fvco <= FV_W'(r_nmp)) && (REM_W'(r_fvco) <= REM_W'(r_nmp));
            end
            S_DIV1, S_DIV2: begin
                w_div_cmd.step = 1'b1;
            end
            S_SAT: begin
                w_div_cmd.load = (r_x < (XW'(w_pfd) << FRAC_BITS));
                w_div_steps    = CNT_W'(FRAC_BITS);
                w_div_ld_part  = w_x_ext[FRAC_BITS +: PFD_W];
                w_div_ld_low   = LW'(w_x_ext[FRAC_BITS-1:0]) << (LW - FRAC_BITS);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_RANGE;
                    end
                end
                S_RANGE: r_state <= w_out_of_range ? S_DONE : S_ODIV;
                S_ODIV:  r_state <= S_VCO;
                S_VCO:   r_state <= S_WIN;
                S_WIN:   r_state <= w_div_cmd.load ? S_DIV1 : S_XMUL;
                S_DIV1: begin
                    if (w_div_done) begin
                        r_state <= S_NFIX;
                    end
                end
                S_NFIX:  r_state <= S_XMUL;
                S_XMUL:  r_state <= S_SAT;
                S_SAT:   r_state <= w_div_cmd.load ? S_DIV2 : S_DONE;
                S_DIV2: begin
                    if (w_div_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_freq    <= i_freq_hz;
                    r_retries <= i_retries_left;
                end
            end
            S_RANGE: begin
                r_f      <= w_f;
                r_status <= w_out_of_range ? ST_RANGE : ST_OK;
                r_odiv   <= '0;
                r_win    <= '0;
                r_nm1    <= '0;
                r_frac   <= '0;
            end
            S_ODIV: begin
                r_odiv <= w_odiv;
                r_nmp  <= NMP_W'(N_MAX) * NMP_W'(w_pfd);
            end
            S_VCO: begin
                r_fvco <= FV_W'(r_f) * FV_W'(r_odiv);
            end
            S_WIN: begin
                r_win <= pick_window(r_fvco);
                // When N clamps, the remainder runs past one pfd period.
                if (!w_div_cmd.load) begin
                    r_nm1 <= NW'(N_MAX - 1);
                    r_rem <= w_fv_ext - REM_W'(r_nmp) + REM_W'(w_pfd);
                end
            end
            S_NFIX: begin
                if (w_div_part != '0) begin
                    r_nm1 <= w_q;
                    r_rem <= REM_W'(w_div_part);
                end else if (w_q != '0) begin
                    r_nm1 <= w_q - 1'b1;
                    r_rem <= REM_W'(w_pfd);
                end else begin
                    r_nm1 <= '0;
                    r_rem <= '0;
                end
            end
            S_XMUL: begin
                r_x <= (XW'(r_rem) << FRAC_BITS) - XW'(r_rem);
            end
            S_SAT: begin
                if (!w_div_cmd.load) begin
                    r_frac   <= '1;
                    r_status <= ST_SAT;
                end
            end
            S_DIV2: begin
                if (w_div_done) begin
                    r_frac <= w_div_low[FRAC_BITS-1:0];
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_o_status <= r_status;
                    r_o_div    <= r_odiv;
                    r_o_win    <= r_win;
                    r_o_nword  <= w_n_ext[NWORD_W-1:0];
                    r_o_frac   <= w_f_ext[FWORD_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_out_div     = r_o_div;
    assign o_lock_window = r_o_win;
    assign o_n_word      = r_o_nword;
    assign o_frac_word   = r_o_frac;

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("request taken while a previous one is still being planned");

    a_range_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_RANGE) |->
            (o_out_div == '0 && o_lock_window == '0 && o_n_word == '0 && o_frac_word == '0))
        else $error("rejected request carries nonzero fields");

    a_sat_frac_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == ST_SAT) |-> (r_frac == {FRAC_BITS{1'b1}}))
        else $error("saturated fraction is not full scale");

    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV1 || r_state == S_DIV2) |-> (w_div_part < w_pfd))
        else $error("partial remainder reached the divisor");

    a_done_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_cmd.load |=> !w_div_done)
        else $error("divider reports done right after a load");

endmodule

// File: verif/frac_n_pll_divider_planner_test.sv
module frac_n_pll_divider_planner_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fnp_pkg::*;

    localparam longint unsigned MHZ_HZ        = 64'd1000000;
    localparam longint unsigned BAND_FLOOR_HZ = 64'd500000;
    localparam longint unsigned BAND_CEIL_HZ  = 64'd1500000000;
    localparam longint unsigned FRAC_FULL     = (64'd1 << FRAC_BITS_DEF) - 64'd1;
    localparam int              STALL_MAX     = 10;
    localparam int              DRAIN_PAD     = 100;
    localparam int              IDLE_LIMIT    = 2000;
    localparam int              REPORT_CAP    = 40;
    localparam int              PHASES        = 11;
    localparam int              PHASE_ITEMS   = 100;

    // Divider bands in MHz: low edge exclusive, high edge inclusive; row r gives 6 - r.
    localparam int unsigned DIVROW_LO_MHZ [3][6] = '{
        '{373, 448, 560, 747, 1120, 2240},
        '{640, 768, 960, 1280, 1920, 3840},
        '{700, 1065, 1278, 1598, 2130, 4200}
    };
    localparam int unsigned DIVROW_HI_MHZ [3][6] = '{
        '{623, 748, 935, 1247, 1870, 3740},
        '{965, 1158, 1448, 1930, 2895, 5790},
        '{1065, 1278, 1598, 2130, 3195, 6390}
    };
    localparam int unsigned WINDOW_MHZ [8] = '{2970, 2000, 1390, 941, 646, 431, 294, 196};

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [DIV_W-1:0]   out_div;
        logic [WIN_W-1:0]   lock_window;
        logic [NWORD_W-1:0] n_word;
        logic [FWORD_W-1:0] frac_word;
    } t_plan;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [FREQ_W-1:0]    i_freq_hz;
    logic [RETRY_W-1:0]   i_retries_left;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [STAT_W-1:0]    o_status;
    logic [DIV_W-1:0]     o_out_div;
    logic [WIN_W-1:0]     o_lock_window;
    logic [NWORD_W-1:0]   o_n_word;
    logic [FWORD_W-1:0]   o_frac_word;

    // Shadow copy of the configuration registers.
    logic [IF_W-1:0]         cur_if;
    logic signed [OFS_W-1:0] cur_ofs;
    logic [PFD_W-1:0]        cur_pfd;
    logic [VAR_W-1:0]        cur_var;

    t_plan plan_q[$];
    int    mismatches  = 0;
    int    idle_cycles = 0;
    bit    quiet       = 1'b0;

    always #1 i_clk = ~i_clk;

    frac_n_pll_divider_planner DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_freq_hz      (i_freq_hz),
        .i_retries_left (i_retries_left),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_out_div      (o_out_div),
        .o_lock_window  (o_lock_window),
        .o_n_word       (o_n_word),
        .o_frac_word    (o_frac_word)
    );

    function automatic t_plan predict_plan(input logic [FREQ_W-1:0]  freq,
                                           input logic [RETRY_W-1:0] retries);
        t_plan           p;
        longint unsigned fq, pfd, f, odiv, fvco, win, n, rem, frac;
        longint          adj;
        bit              hit;
        p  = '0;
        fq = 64'(freq);
        pfd = (cur_pfd == '0) ? 64'd1 : 64'(cur_pfd);
        if (fq < 64'(cur_if) + BAND_FLOOR_HZ || fq > 64'(cur_if) + BAND_CEIL_HZ) begin
            p.status = ST_RANGE;
            return p;
        end
        adj = longint'(fq) + longint'(cur_ofs);
        f = (adj < 0) ? 64'd0 : $unsigned(adj);

        odiv = 64'd1;
        hit  = 1'b0;
        if (cur_var <= VAR_LAST) begin
            for (int r = 0; r < 6; r++) begin
                if (!hit && f > 64'(DIVROW_LO_MHZ[cur_var][r]) * MHZ_HZ
                         && f <= 64'(DIVROW_HI_MHZ[cur_var][r]) * MHZ_HZ) begin
                    odiv = 64'(6 - r);
                    hit  = 1'b1;
                end
            end
        end
        if (retries == RETRY_UP) odiv = odiv + 1;
        if (retries == RETRY_DOWN) odiv = odiv - 1;

        fvco = f * odiv;
        win  = 64'd1;
        hit  = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (!hit && fvco >= 64'(WINDOW_MHZ[k]) * MHZ_HZ) begin
                win = 64'(k);
                hit = 1'b1;
            end
        end

        n = (fvco + pfd - 1) / pfd;
        if (n < 1) n = 1;
        if (n > N_MAX_DEF) n = N_MAX_DEF;
        rem  = fvco - (n - 1) * pfd;
        frac = (rem * FRAC_FULL) / pfd;
        p.status = ST_OK;
        if (frac > FRAC_FULL) begin
            frac     = FRAC_FULL;
            p.status = ST_SAT;
        end
        p.out_div     = DIV_W'(odiv);
        p.lock_window = WIN_W'(win);
        p.n_word      = NWORD_W'(n - 1);
        p.frac_word   = FWORD_W'(frac);
        return p;
    endfunction

    function automatic int draw_wait();
        if (quiet || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(1, STALL_MAX);
    endfunction

    // Predict on every accepted request and compare every accepted result.
    always @(posedge i_clk) begin : scoreboard
        t_plan seen, want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                plan_q.push_back(predict_plan(i_freq_hz, i_retries_left));
            end
            if (o_out_valid && i_out_ready) begin
                seen = {o_status, o_out_div, o_lock_window, o_n_word, o_frac_word};
                if (plan_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP) begin
                        $display("%0t: result with no request pending: status %0d div %0d",
                                 $time, seen.status, seen.out_div);
                    end
                end else begin
                    want = plan_q.pop_front();
                    if (seen !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_CAP) begin
                            $display({"%0t: expected status %0d div %0d win %0d n %0d frac %0d,",
                                      " got status %0d div %0d win %0d n %0d frac %0d"},
                                     $time, want.status, want.out_div, want.lock_window,
                                     want.n_word, want.frac_word, seen.status, seen.out_div,
                                     seen.lock_window, seen.n_word, seen.frac_word);
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: random stall before each result is taken.
    initial begin : result_side
        int stall;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    task automatic send_request(input logic [FREQ_W-1:0]  freq,
                                input logic [RETRY_W-1:0] retries);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_freq_hz      <= freq;
        i_retries_left <= retries;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (plan_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_IF:      cur_if  = data[IF_W-1:0];
            CFG_OFFSET:  cur_ofs = data[OFS_W-1:0];
            CFG_PFD:     cur_pfd = data[PFD_W-1:0];
            CFG_VARIANT: cur_var = data[VAR_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [CFG_W-1:0] if_word, input logic [CFG_W-1:0] ofs_word,
                                input logic [CFG_W-1:0] pfd_word, input logic [CFG_W-1:0] var_word);
        wait_drain();
        write_reg(CFG_IF, if_word);
        write_reg(CFG_OFFSET, ofs_word);
        write_reg(CFG_PFD, pfd_word);
        write_reg(CFG_VARIANT, var_word);
    endtask

    // Band edges and retry counts under the register values left by reset.
    task automatic test_reset_defaults();
        send_request(33'd0, 3'd0);
        send_request(33'd499999, 3'd3);
        send_request(33'd500000, 3'd0);
        send_request(33'd1500000000, 3'd7);
        send_request(33'd1500000001, 3'd4);
        send_request('1, 3'd5);
    endtask

    task automatic test_retry_adjust();
        send_request(33'd900000000, RETRY_UP);
        send_request(33'd900000000, RETRY_DOWN);
        // No band matches, so lowering the divider leaves zero.
        send_request(33'd100000000, RETRY_DOWN);
        send_request(33'd100000000, RETRY_UP);
    endtask

    task automatic test_offset_limits();
        // A negative sum is taken as 0 Hz.
        apply_config(32'd0, -100000000, 32'd10000000, 32'd1);
        send_request(33'd500000, 3'd0);
        apply_config(32'd0, 32'h0800_0000, 32'd10000000, 32'd1);
        send_request(33'd1000000000, RETRY_UP);
        apply_config(32'd0, 32'd100000000, 32'd10000000, 32'd1);
        send_request(33'd1500000000, 3'd0);
    endtask

    task automatic test_part_variants();
        apply_config(32'd0, 32'd0, 32'd10000000, 32'd0);
        send_request(33'd623000000, 3'd0);
        send_request(33'd623000001, 3'd0);
        apply_config(32'd0, 32'd0, 32'd10000000, 32'd2);
        send_request(33'd1065000000, 3'd0);
        send_request(33'd1065000001, 3'd0);
        // The fourth variant has no ladder at all.
        apply_config(32'd0, 32'd0, 32'd10000000, 32'd3);
        send_request(33'd1000000000, RETRY_UP);
    endtask

    task automatic test_pfd_limits();
        apply_config(32'd0, 32'd0, 32'd0, 32'd1);
        send_request(33'd1000000000, 3'd0);
        apply_config(32'd0, 32'd0, 32'h07FF_FFFF, 32'd1);
        send_request(33'd1000000000, 3'd7);
    endtask

    task automatic test_fraction_saturation();
        // N lands exactly on the clamp, just past it, and far past it.
        apply_config(32'd0, 32'd0, 32'd1000000, 32'd3);
        send_request(33'd1023000000, 3'd0);
        send_request(33'd1023000004, 3'd0);
        send_request(33'd1500000000, 3'd0);
    endtask

    task automatic test_if_extremes();
        apply_config(32'd4000000000, 32'd0, 32'd10000000, 32'd2);
        send_request(33'd4000499999, 3'd0);
        send_request(33'd4000500000, RETRY_DOWN);
        send_request(33'd5500000000, RETRY_UP);
    endtask

    task automatic test_unknown_register();
        apply_config(32'd0, 32'd0, 32'd10000000, 32'd1);
        for (int k = CFG_VARIANT + 1; k < (1 << CFG_IDX_W); k++) begin
            write_reg(CFG_IDX_W'(k), '1);
        end
        send_request(33'd1000000000, 3'd0);
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0]   w_if, w_ofs, w_pfd, w_var;
        logic [RETRY_W-1:0] retries;
        longint unsigned    pick, base, bound;
        longint             target;
        int                 row, vi;
        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0:       w_if = 32'd0;
                1:       w_if = 32'd4000000000;
                default: w_if = $urandom_range(0, 32'd3000000000);
            endcase
            case ($urandom_range(0, 4))
                0:       w_ofs = -100000000;
                1:       w_ofs = 32'd100000000;
                2:       w_ofs = 32'd0;
                3:       w_ofs = $urandom;
                default: w_ofs = $urandom_range(0, 200000000) - 32'd100000000;
            endcase
            case ($urandom_range(0, 5))
                0:       w_pfd = 32'd1000000;
                1:       w_pfd = 32'd100000000;
                2:       w_pfd = 32'd0;
                3:       w_pfd = 32'h07FF_FFFF;
                default: w_pfd = $urandom_range(1000000, 100000000);
            endcase
            // Upper bits beyond each register's width must be dropped by the block.
            w_pfd = w_pfd | ($urandom & 32'hF800_0000);
            w_var = $urandom;
            apply_config(w_if, w_ofs, w_pfd, w_var);
            quiet = (ph % 4 == 1);
            vi = (cur_var > VAR_LAST) ? int'(VAR_LAST) : int'(cur_var);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                base = 64'(cur_if) + BAND_FLOOR_HZ;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin
                        pick = base + $urandom_range(0, 32'(BAND_CEIL_HZ - BAND_FLOOR_HZ));
                    end
                    6, 7: begin
                        // Aim the corrected frequency at a divider band edge.
                        row = $urandom_range(0, 5);
                        bound = $urandom_range(0, 1) ? 64'(DIVROW_HI_MHZ[vi][row])
                                                     : 64'(DIVROW_LO_MHZ[vi][row]);
                        target = longint'(bound * MHZ_HZ) - longint'(cur_ofs)
                                 + longint'($urandom_range(0, 4)) - 2;
                        pick = $unsigned(target);
                    end
                    8: begin
                        if ($urandom_range(0, 1)) begin
                            pick = base + $urandom_range(0, 2) - 1;
                        end else begin
                            pick = 64'(cur_if) + BAND_CEIL_HZ + $urandom_range(0, 2) - 1;
                        end
                    end
                    default: pick = {$urandom_range(0, 1), $urandom};
                endcase
                if ($urandom_range(0, 1)) begin
                    retries = $urandom_range(0, 1) ? RETRY_UP : RETRY_DOWN;
                end else begin
                    retries = RETRY_W'($urandom_range(0, 7));
                end
                send_request(FREQ_W'(pick), retries);
                if ($urandom_range(0, 79) == 0) wait_drain();
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_freq_hz      = '0;
        i_retries_left = '0;
        cur_if         = '0;
        cur_ofs        = '0;
        cur_pfd        = 27'd10000000;
        cur_var        = 2'd1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_retry_adjust();
        test_offset_limits();
        test_part_variants();
        test_pfd_limits();
        test_fraction_saturation();
        test_if_extremes();
        test_unknown_register();
        test_random_traffic();

        wait_drain();
        repeat (DRAIN_PAD) @(posedge i_clk);
        if (mismatches == 0 && plan_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
